// ===== design/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg: shared types and sizes for the context binding table
// Holds the table depth, index widths, action codes and the slot and compare
// structs.
// ----------------------------------------------------------------------------
package cbt_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Action codes carried on in_action.
  localparam logic ACT_QUERY  = 1'b0;
  localparam logic ACT_RECORD = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  // One binding as stored in a slot.
  typedef struct packed {
    logic [31:0] key_high;
    logic [31:0] key_low;
    logic [31:0] region_start;
    logic [31:0] region_size;
    logic [31:0] globals_base;
    logic [31:0] stack_start;
  } entry_t;

  // Outcome of comparing one slot against the current item.
  typedef struct packed {
    logic key_eq;
    logic ctx_eq;
    logic free;
  } cmp_t;

endpackage

// ===== design/context_binding_table.sv =====
// ----------------------------------------------------------------------------
// context_binding_table: small associative table of process context bindings
// Each slot binds a 64-bit process key to four context words. Queries look
// for an exact binding; records update the slot holding the key, else fill
// the lowest free slot, else replace a round-robin victim.
// ----------------------------------------------------------------------------
// Flow: a zero-key beat goes straight to the hand-off state; other beats pass
// a read state, a scan that compares one slot per cycle, a write state for
// records, and the hand-off state into the output register.
// The input stalls until the result is handed on, so a new beat is not taken
// before the last one is through.
// Reset (rst_n, synchronous, active low) clears all slot valid bits and the
// victim pointer, so every slot reads as all zero (free).
// ----------------------------------------------------------------------------
module context_binding_table (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_key_high,
  input  logic [31:0] in_key_low,
  input  logic [31:0] in_region_start,
  input  logic [31:0] in_region_size,
  input  logic [31:0] in_globals_base,
  input  logic [31:0] in_stack_start,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_matched,
  output logic        out_key_rejected
);
  import cbt_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,  // waiting for an input beat
    S_FETCH = 5'b00010,  // first slot read in flight
    S_SCAN  = 5'b00100,  // compare one slot per cycle
    S_WRITE = 5'b01000,  // record: write the chosen slot
    S_DONE  = 5'b10000   // hand the result to the output register
  } state_t;

  state_t state_r, state_nxt;

  // Latched item. Payload registers carry no reset.
  entry_t item_r;
  logic   action_r;

  // Slot memory with a registered read port, plus per-slot valid bits so
  // that reset makes every slot read as all zero without a clearing pass.
  entry_t                   mem [TABLE_ENTRIES];
  entry_t                   rd_data_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  idx_t rd_idx_r,  rd_idx_nxt;    // address being read this cycle
  idx_t cmp_idx_r, cmp_idx_nxt;   // slot whose data sits in rd_data_r
  idx_t free_idx_r, free_idx_nxt;
  logic have_free_r, have_free_nxt;
  idx_t target_r, target_nxt;
  idx_t victim_r, victim_nxt;
  logic matched_r, matched_nxt;
  logic rejected_r, rejected_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_matched_r, out_matched_nxt;
  logic out_rejected_r, out_rejected_nxt;

  logic   in_fire;
  logic   mem_we;
  entry_t slot_view;
  cmp_t   cmp;
  logic   out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign mem_we   = (state_r == S_WRITE);

  // A slot never written since reset reads as all zero, i.e. free.
  assign slot_view = valid_r[cmp_idx_r] ? rd_data_r : '0;

  cbt_slot_cmp u_cmp (
    .slot (slot_view),
    .item (item_r),
    .res  (cmp)
  );

  // Sequencer and scan bookkeeping.
  always_comb begin
    state_nxt        = state_r;
    rd_idx_nxt       = rd_idx_r;
    cmp_idx_nxt      = cmp_idx_r;
    free_idx_nxt     = free_idx_r;
    have_free_nxt    = have_free_r;
    target_nxt       = target_r;
    victim_nxt       = victim_r;
    matched_nxt      = matched_r;
    rejected_nxt     = rejected_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_matched_nxt  = out_matched_r;
    out_rejected_nxt = out_rejected_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          matched_nxt   = 1'b0;
          have_free_nxt = 1'b0;
          rd_idx_nxt    = '0;
          if ((in_key_high == 32'd0) && (in_key_low == 32'd0)) begin
            // Zero key: ignore the beat and flag it.
            rejected_nxt = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            rejected_nxt = 1'b0;
            state_nxt    = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        cmp_idx_nxt = rd_idx_r;
        if (rd_idx_r != LAST_IDX) begin
          rd_idx_nxt = rd_idx_r + idx_t'(1);
        end
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        cmp_idx_nxt = rd_idx_r;
        if (rd_idx_r != LAST_IDX) begin
          rd_idx_nxt = rd_idx_r + idx_t'(1);
        end
        if (action_r == ACT_QUERY) begin
          // Query: hit needs key and all context words equal.
          if (cmp.key_eq && cmp.ctx_eq) begin
            matched_nxt = 1'b1;
            state_nxt   = S_DONE;
          end else if (cmp_idx_r == LAST_IDX) begin
            state_nxt = S_DONE;
          end
        end else begin
          if (cmp.key_eq) begin
            // The slot already holding the key wins over any free slot.
            target_nxt = cmp_idx_r;
            state_nxt  = S_WRITE;
          end else begin
            if (cmp.free && !have_free_r) begin
              have_free_nxt = 1'b1;
              free_idx_nxt  = cmp_idx_r;
            end
            if (cmp_idx_r == LAST_IDX) begin
              state_nxt = S_WRITE;
              if (have_free_r) begin
                target_nxt = free_idx_r;
              end else if (cmp.free) begin
                target_nxt = cmp_idx_r;
              end else begin
                // Table full: replace the victim and advance the pointer.
                target_nxt = victim_r;
                victim_nxt = (victim_r == LAST_IDX) ? '0 : victim_r + idx_t'(1);
              end
            end
          end
        end
      end

      S_WRITE: begin
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_matched_nxt  = matched_r;
          out_rejected_nxt = rejected_r;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      victim_r    <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      victim_r    <= victim_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        valid_r[target_r] <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_r            <= in_action;
      item_r.key_high     <= in_key_high;
      item_r.key_low      <= in_key_low;
      item_r.region_start <= in_region_start;
      item_r.region_size  <= in_region_size;
      item_r.globals_base <= in_globals_base;
      item_r.stack_start  <= in_stack_start;
    end
    rd_idx_r       <= rd_idx_nxt;
    cmp_idx_r      <= cmp_idx_nxt;
    free_idx_r     <= free_idx_nxt;
    have_free_r    <= have_free_nxt;
    target_r       <= target_nxt;
    matched_r      <= matched_nxt;
    rejected_r     <= rejected_nxt;
    out_matched_r  <= out_matched_nxt;
    out_rejected_r <= out_rejected_nxt;
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[target_r] <= item_r;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  assign out_valid        = out_valid_r;
  assign out_matched      = out_matched_r;
  assign out_key_rejected = out_rejected_r;

endmodule

// ===== design/cbt_slot_cmp.sv =====
// ----------------------------------------------------------------------------
// cbt_slot_cmp: compare unit shared across the table scan
// Checks one slot against the item: key equality, context equality, free.
// ----------------------------------------------------------------------------
module cbt_slot_cmp (
  input  cbt_pkg::entry_t slot,
  input  cbt_pkg::entry_t item,
  output cbt_pkg::cmp_t   res
);
  import cbt_pkg::*;

  always_comb begin
    res.key_eq = (slot.key_high == item.key_high) && (slot.key_low == item.key_low);
    res.ctx_eq = (slot.region_start == item.region_start)
              && (slot.region_size == item.region_size)
              && (slot.globals_base == item.globals_base)
              && (slot.stack_start == item.stack_start);
    res.free   = (slot.key_high == 32'd0) && (slot.key_low == 32'd0);
  end

endmodule
